/* sv/assert_macros.svh */
// Assertion macros shared by the record store selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/dprs_pkg.sv */
// Package with the types, constants and functions of the record store selector.
`timescale 1ns / 1ps
`default_nettype none
package dprs_pkg;

   localparam int THRESH_COUNT = 9;

   localparam logic signed [8:0] TEMP_STEPS [THRESH_COUNT] = '{
      9'sd60, 9'sd92, 9'sd111, 9'sd123, 9'sd131, 9'sd138, 9'sd142, 9'sd146, 9'sd149
   };

   localparam logic [3:0] STEP_MIN = 4'd1;
   localparam logic [3:0] STEP_MAX = 4'd10;

   localparam logic PAGE_FIRST  = 1'b0;
   localparam logic PAGE_SECOND = 1'b1;

   typedef struct packed {
      logic        target_page;
      logic [3:0]  page_id;
      logic [3:0]  count_high;
      logic [15:0] count_low;
      logic [3:0]  step;
      logic [15:0] param_low;
      logic [15:0] param_high;
   } dprs_sel_type;

   typedef struct packed {
      logic        target_page;
      logic [3:0]  page_id;
      logic [3:0]  count_high;
      logic [16:0] sum;
      logic [15:0] param_low;
      logic [15:0] param_high;
   } dprs_sum_type;

   typedef struct packed {
      logic        target_page;
      logic [3:0]  new_page_id;
      logic [3:0]  new_count_high;
      logic [15:0] new_count_low;
      logic [15:0] out_param_low;
      logic [15:0] out_param_high;
   } dprs_rsp_type;

   // The increment is one plus the number of thresholds at or below the temperature.
   function automatic logic [3:0] temp_step(input logic signed [8:0] temp);
      logic [3:0] n;
      n = STEP_MIN;
      for (int k = 0; k < THRESH_COUNT; k++) begin
         if (temp >= TEMP_STEPS[k]) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

/* sv/dprs_ifs.sv */
// Request and response channel interfaces of the record store selector.
`timescale 1ns / 1ps
`default_nettype none
interface dprs_req_if;
   logic              valid;
   logic              ready;
   logic              first_valid;
   logic              second_valid;
   logic [3:0]        first_page_id;
   logic [3:0]        second_page_id;
   logic [3:0]        first_count_high;
   logic [15:0]       first_count_low;
   logic [3:0]        second_count_high;
   logic [15:0]       second_count_low;
   logic signed [8:0] chip_temperature;
   logic [15:0]       param_low;
   logic [15:0]       param_high;

   modport source (
      output valid, first_valid, second_valid, first_page_id, second_page_id,
      output first_count_high, first_count_low, second_count_high, second_count_low,
      output chip_temperature, param_low, param_high,
      input  ready
   );

   modport sink (
      input  valid, first_valid, second_valid, first_page_id, second_page_id,
      input  first_count_high, first_count_low, second_count_high, second_count_low,
      input  chip_temperature, param_low, param_high,
      output ready
   );
endinterface

interface dprs_rsp_if;
   logic        valid;
   logic        ready;
   logic        target_page;
   logic [3:0]  new_page_id;
   logic [3:0]  new_count_high;
   logic [15:0] new_count_low;
   logic [15:0] out_param_low;
   logic [15:0] out_param_high;

   modport source (
      output valid, target_page, new_page_id, new_count_high, new_count_low,
      output out_param_low, out_param_high,
      input  ready
   );

   modport sink (
      input  valid, target_page, new_page_id, new_count_high, new_count_low,
      input  out_param_low, out_param_high,
      output ready
   );
endinterface
`default_nettype wire

/* sv/dprs_select.sv */
// First stage: page selection, base counter and temperature increment.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dprs_select
   import dprs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   dprs_req_if.sink    req,
   output dprs_sel_type sel,
   output logic        sel_valid,
   input  wire logic   sel_ready
);

   dprs_sel_type sel_ff, sel_in;
   logic         valid_ff;
   logic         first_le;

   assign req.ready = !valid_ff || sel_ready;
   assign first_le  = {req.first_count_high, req.first_count_low}
                      <= {req.second_count_high, req.second_count_low};

   always_comb begin
      sel_in.step       = temp_step(req.chip_temperature);
      sel_in.param_low  = req.param_low;
      sel_in.param_high = req.param_high;
      if (req.first_valid && req.second_valid && first_le) begin
         sel_in.target_page = PAGE_FIRST;
         sel_in.page_id     = req.second_page_id;
         sel_in.count_high  = req.first_count_high;
         sel_in.count_low   = req.first_count_low;
      end else if (req.first_valid && req.second_valid) begin
         sel_in.target_page = PAGE_SECOND;
         sel_in.page_id     = req.first_page_id ^ 4'd1;
         sel_in.count_high  = req.second_count_high;
         sel_in.count_low   = req.second_count_low;
      end else if (req.first_valid) begin
         sel_in.target_page = PAGE_SECOND;
         sel_in.page_id     = req.first_page_id ^ 4'd1;
         sel_in.count_high  = req.first_count_high;
         sel_in.count_low   = req.first_count_low;
      end else if (req.second_valid) begin
         sel_in.target_page = PAGE_FIRST;
         sel_in.page_id     = req.second_page_id;
         sel_in.count_high  = req.second_count_high;
         sel_in.count_low   = req.second_count_low;
      end else begin
         sel_in.target_page = PAGE_FIRST;
         sel_in.page_id     = 4'd0;
         sel_in.count_high  = 4'd0;
         sel_in.count_low   = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         sel_ff <= sel_in;
      end
   end

   assign sel       = sel_ff;
   assign sel_valid = valid_ff;

   `ASSERT_NEXT(a_default_record, clock, reset,
      req.valid && req.ready && !req.first_valid && !req.second_valid,
      sel_ff.target_page == PAGE_FIRST && sel_ff.page_id == 4'd0 &&
      sel_ff.count_high == 4'd0 && sel_ff.count_low == 16'd0,
      "default record not selected when both pages are invalid")
   `ASSERT_SAME(a_step_range, clock, reset, valid_ff,
      sel_ff.step >= STEP_MIN && sel_ff.step <= STEP_MAX,
      "temperature increment out of range")

endmodule
`default_nettype wire

/* sv/dprs_add.sv */
// Second stage: adds the temperature increment to the lower counter bits.
`timescale 1ns / 1ps
`default_nettype none
module dprs_add
   import dprs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dprs_sel_type  sel,
   input  wire logic          sel_valid,
   output logic               sel_ready,
   output dprs_sum_type       sum,
   output logic               sum_valid,
   input  wire logic          sum_ready
);

   dprs_sum_type sum_ff, sum_in;
   logic         valid_ff;

   assign sel_ready = !valid_ff || sum_ready;

   always_comb begin
      sum_in.target_page = sel.target_page;
      sum_in.page_id     = sel.page_id;
      sum_in.count_high  = sel.count_high;
      sum_in.sum         = {1'b0, sel.count_low} + {13'd0, sel.step};
      sum_in.param_low   = sel.param_low;
      sum_in.param_high  = sel.param_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel_ready) begin
         valid_ff <= sel_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_ready && sel_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign sum       = sum_ff;
   assign sum_valid = valid_ff;

endmodule
`default_nettype wire

/* sv/dprs_carry.sv */
// Third stage: carries into the upper counter bits and holds the response.
`timescale 1ns / 1ps
`default_nettype none
module dprs_carry
   import dprs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dprs_sum_type  sum,
   input  wire logic          sum_valid,
   output logic               sum_ready,
   dprs_rsp_if.source         rsp
);

   dprs_rsp_type rsp_ff, rsp_in;
   logic         valid_ff;

   assign sum_ready = !valid_ff || rsp.ready;

   always_comb begin
      rsp_in.target_page    = sum.target_page;
      rsp_in.new_page_id    = sum.page_id;
      rsp_in.new_count_high = sum.count_high + {3'd0, sum.sum[16]};
      rsp_in.new_count_low  = sum.sum[15:0];
      rsp_in.out_param_low  = sum.param_low;
      rsp_in.out_param_high = sum.param_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_ready) begin
         valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && sum_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.target_page    = rsp_ff.target_page;
   assign rsp.new_page_id    = rsp_ff.new_page_id;
   assign rsp.new_count_high = rsp_ff.new_count_high;
   assign rsp.new_count_low  = rsp_ff.new_count_low;
   assign rsp.out_param_low  = rsp_ff.out_param_low;
   assign rsp.out_param_high = rsp_ff.out_param_high;

endmodule
`default_nettype wire

/* sv/dual_page_record_store_selector_top.sv */
// Top level of the dual page record store selector.
// The block takes one store request per cycle unless the response side holds it, and
// passes each request through its three register stages: page selection with the
// temperature increment, the lower counter add, and the upper counter carry, which
// is also the output register. Each stage fills while a later one is stalled, so
// up to three requests are in flight, and the request side is held only when all
// three stages are full and the response is not taken. There is no configuration
// and no stored state between requests; reset only empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dual_page_record_store_selector_top
   import dprs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dprs_req_if.sink   req_ch,
   dprs_rsp_if.source rsp_ch
);

   dprs_sel_type sel;
   dprs_sum_type sum;
   logic         sel_valid;
   logic         sel_ready;
   logic         sum_valid;
   logic         sum_ready;

   dprs_select u_select (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .sel       (sel),
      .sel_valid (sel_valid),
      .sel_ready (sel_ready)
   );

   dprs_add u_add (
      .clock     (clock),
      .reset     (reset),
      .sel       (sel),
      .sel_valid (sel_valid),
      .sel_ready (sel_ready),
      .sum       (sum),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready)
   );

   dprs_carry u_carry (
      .clock     (clock),
      .reset     (reset),
      .sum       (sum),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .rsp       (rsp_ch)
   );

   `ASSERT_SAME(a_full_when_blocked, clock, reset, !req_ch.ready,
      $countones({sel_valid, sum_valid, rsp_ch.valid}) == 3 && !rsp_ch.ready,
      "request side held while the pipeline has room")

endmodule
`default_nettype wire

/* tb/tb_dual_page_record_store_selector_top.sv */
// Self-checking testbench of the dual page record store selector.
`timescale 1ns / 1ps
module tb_dual_page_record_store_selector_top
   import dprs_pkg::*;
();

   localparam int RANDOM_PER_PHASE = 250;
   localparam int BURST_ITEMS      = 24;
   localparam int HOLD_OFF_CYCLES  = 60;
   localparam int TAIL_CYCLES      = 8;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int REPORT_LIMIT     = 10;
   localparam int TEMP_LIMITS [9]  = '{60, 92, 111, 123, 131, 138, 142, 146, 149};

   typedef struct packed {
      logic        first_valid;
      logic        second_valid;
      logic [3:0]  first_page_id;
      logic [3:0]  second_page_id;
      logic [3:0]  first_count_high;
      logic [15:0] first_count_low;
      logic [3:0]  second_count_high;
      logic [15:0] second_count_low;
      logic [8:0]  chip_temperature;
      logic [15:0] param_low;
      logic [15:0] param_high;
   } store_req_type;

   typedef struct {
      store_req_type req;
      bit            fixed;
      dprs_rsp_type  record;
   } directed_row_type;

   logic clock;
   logic reset;

   dprs_req_if req_ch ();
   dprs_rsp_if rsp_ch ();

   dual_page_record_store_selector_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dprs_rsp_type     pending_records [$];
   directed_row_type directed_rows [$];
   int               fault_count;
   int               stalled_cycles;
   int unsigned      req_gap_pct;
   int unsigned      rsp_stall_pct;
   int               hold_off_requests;
   int               hold_off_served;
   int               hold_left;
   int unsigned      phase_gap_pct [4]   = '{0, 78, 0, 9};
   int unsigned      phase_stall_pct [4] = '{0, 0, 78, 9};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic dprs_rsp_type predict_record(input store_req_type r);
      dprs_rsp_type rec;
      logic [3:0]   base_high;
      logic [15:0]  base_low;
      logic [16:0]  sum;
      int           temp_c;
      int           step;
      temp_c = $signed(r.chip_temperature);
      step = 1;
      foreach (TEMP_LIMITS[k]) begin
         if (temp_c >= TEMP_LIMITS[k]) begin
            step++;
         end
      end
      if (r.first_valid && r.second_valid) begin
         if ({r.first_count_high, r.first_count_low} <=
             {r.second_count_high, r.second_count_low}) begin
            rec.target_page = PAGE_FIRST;
            rec.new_page_id = r.second_page_id;
            base_high = r.first_count_high;
            base_low = r.first_count_low;
         end else begin
            rec.target_page = PAGE_SECOND;
            rec.new_page_id = r.first_page_id ^ 4'd1;
            base_high = r.second_count_high;
            base_low = r.second_count_low;
         end
      end else if (r.first_valid) begin
         rec.target_page = PAGE_SECOND;
         rec.new_page_id = r.first_page_id ^ 4'd1;
         base_high = r.first_count_high;
         base_low = r.first_count_low;
      end else if (r.second_valid) begin
         rec.target_page = PAGE_FIRST;
         rec.new_page_id = r.second_page_id;
         base_high = r.second_count_high;
         base_low = r.second_count_low;
      end else begin
         rec.target_page = PAGE_FIRST;
         rec.new_page_id = 4'd0;
         base_high = 4'd0;
         base_low = 16'd0;
      end
      sum = {1'b0, base_low} + 17'(step);
      rec.new_count_low = sum[15:0];
      rec.new_count_high = base_high + 4'(sum[16]);
      rec.out_param_low = r.param_low;
      rec.out_param_high = r.param_high;
      return rec;
   endfunction

   function automatic directed_row_type dir_row(input bit fv, input bit sv,
                                             input logic [3:0] id1, input logic [3:0] id2,
                                             input logic [19:0] c1, input logic [19:0] c2,
                                             input int temp_c,
                                             input logic [15:0] pl, input logic [15:0] ph,
                                             input bit fixed, input logic [24:0] head);
      directed_row_type row;
      row.req = {fv, sv, id1, id2, c1, c2, 9'(temp_c), pl, ph};
      row.fixed = fixed;
      row.record = {head, pl, ph};
      return row;
   endfunction

   function automatic store_req_type random_request();
      store_req_type r;
      int            mode;
      mode = $urandom_range(3);
      r.first_valid = 1'($urandom_range(1));
      r.second_valid = 1'($urandom_range(1));
      r.first_page_id = 4'($urandom);
      r.second_page_id = 4'($urandom);
      {r.first_count_high, r.first_count_low} = 20'($urandom);
      {r.second_count_high, r.second_count_low} = 20'($urandom);
      if (mode == 1) begin
         r.first_count_low = 16'hFFFF - 16'($urandom_range(12));
         r.second_count_low = 16'hFFFF - 16'($urandom_range(12));
      end else if (mode == 2) begin
         {r.second_count_high, r.second_count_low} = {r.first_count_high, r.first_count_low};
      end else if (mode == 3) begin
         {r.second_count_high, r.second_count_low} =
            {r.first_count_high, r.first_count_low} + 20'($urandom_range(2)) - 20'd1;
      end
      if ($urandom_range(1) == 0) begin
         r.chip_temperature = 9'($urandom_range(511));
      end else begin
         r.chip_temperature = 9'($urandom_range(165, 50));
      end
      r.param_low = 16'($urandom);
      r.param_high = 16'($urandom);
      return r;
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   task automatic offer_request(input store_req_type r, input dprs_rsp_type rec);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.first_valid <= r.first_valid;
      req_ch.second_valid <= r.second_valid;
      req_ch.first_page_id <= r.first_page_id;
      req_ch.second_page_id <= r.second_page_id;
      req_ch.first_count_high <= r.first_count_high;
      req_ch.first_count_low <= r.first_count_low;
      req_ch.second_count_high <= r.second_count_high;
      req_ch.second_count_low <= r.second_count_low;
      req_ch.chip_temperature <= r.chip_temperature;
      req_ch.param_low <= r.param_low;
      req_ch.param_high <= r.param_high;
      do @(posedge clock); while (!req_ch.ready);
      pending_records.push_back(rec);
   endtask

   task automatic wait_for_records();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         hold_off_served <= 0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_OFF_CYCLES - 1;
         hold_off_served <= hold_off_served + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      dprs_rsp_type got;
      dprs_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.target_page, rsp_ch.new_page_id, rsp_ch.new_count_high,
                rsp_ch.new_count_low, rsp_ch.out_param_low, rsp_ch.out_param_high};
         if (pending_records.size() == 0) begin
            report_fault($sformatf("response with no request outstanding: %h", got));
         end else begin
            want = pending_records.pop_front();
            if (got.target_page !== want.target_page ||
                got.new_page_id !== want.new_page_id ||
                got.new_count_high !== want.new_count_high ||
                got.new_count_low !== want.new_count_low ||
                got.out_param_low !== want.out_param_low ||
                got.out_param_high !== want.out_param_high) begin
               report_fault($sformatf(
                  {"mismatch: expected page %h id %h count %h_%h params %h_%h, ",
                   "got page %h id %h count %h_%h params %h_%h"},
                  want.target_page, want.new_page_id, want.new_count_high, want.new_count_low,
                  want.out_param_high, want.out_param_low,
                  got.target_page, got.new_page_id, got.new_count_high, got.new_count_low,
                  got.out_param_high, got.out_param_low));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      store_req_type r;
      clock = 1'b0;
      reset = 1'b1;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_off_requests = 0;
      req_ch.valid = 1'b0;
      req_ch.first_valid = 1'b0;
      req_ch.second_valid = 1'b0;
      req_ch.first_page_id = 4'd0;
      req_ch.second_page_id = 4'd0;
      req_ch.first_count_high = 4'd0;
      req_ch.first_count_low = 16'd0;
      req_ch.second_count_high = 4'd0;
      req_ch.second_count_low = 16'd0;
      req_ch.chip_temperature = 9'd0;
      req_ch.param_low = 16'd0;
      req_ch.param_high = 16'd0;

      directed_rows.push_back(dir_row(0, 0, 4'h5, 4'hA, 20'h31234, 20'h20001, 0,
                                      16'h0000, 16'h0000, 1,
                                      {PAGE_FIRST, 4'h0, 4'h0, 16'h0001}));
      directed_rows.push_back(dir_row(0, 0, 4'hF, 4'hF, 20'hFFFFF, 20'hFFFFF, -256,
                                      16'hFFFF, 16'hFFFF, 1,
                                      {PAGE_FIRST, 4'h0, 4'h0, 16'h0001}));
      directed_rows.push_back(dir_row(0, 0, 4'h0, 4'h0, 20'h00000, 20'h00000, 255,
                                      16'hA5A5, 16'h5A5A, 1,
                                      {PAGE_FIRST, 4'h0, 4'h0, 16'h000A}));
      directed_rows.push_back(dir_row(1, 0, 4'hF, 4'h0, 20'hFFFFF, 20'h00000, 255,
                                      16'hFFFF, 16'h0000, 1,
                                      {PAGE_SECOND, 4'hE, 4'h0, 16'h0009}));
      directed_rows.push_back(dir_row(0, 1, 4'hF, 4'h0, 20'hFFFFF, 20'h00000, 59,
                                      16'h0000, 16'hFFFF, 1,
                                      {PAGE_FIRST, 4'h0, 4'h0, 16'h0001}));
      directed_rows.push_back(dir_row(1, 1, 4'h6, 4'h9, 20'h51000, 20'h51000, 60,
                                      16'h1234, 16'h4321, 1,
                                      {PAGE_FIRST, 4'h9, 4'h5, 16'h1002}));
      directed_rows.push_back(dir_row(1, 1, 4'h3, 4'hC, 20'h20000, 20'h1FFFF, 149,
                                      16'h0001, 16'h0001, 1,
                                      {PAGE_SECOND, 4'h2, 4'h2, 16'h0009}));
      directed_rows.push_back(dir_row(1, 1, 4'h0, 4'h1, 20'h7000A, 20'h7000B, 91,
                                      16'h00FF, 16'hFF00, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'h1, 4'h0, 20'h7000C, 20'h7000B, 92,
                                      16'hFF00, 16'h00FF, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'h2, 4'h3, 20'h1FFFF, 20'h20000, 110,
                                      16'h8000, 16'h0001, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'h3, 4'h2, 20'h30000, 20'h2FFFF, 111,
                                      16'h0001, 16'h8000, 0, '0));
      directed_rows.push_back(dir_row(1, 0, 4'h7, 4'h8, 20'h0FFFE, 20'h00000, 122,
                                      16'h5555, 16'hAAAA, 0, '0));
      directed_rows.push_back(dir_row(0, 1, 4'h8, 4'h7, 20'h00000, 20'hFFFF9, 123,
                                      16'hAAAA, 16'h5555, 0, '0));
      directed_rows.push_back(dir_row(1, 0, 4'hA, 4'h5, 20'h8FFF5, 20'h12345, 130,
                                      16'h0F0F, 16'hF0F0, 0, '0));
      directed_rows.push_back(dir_row(0, 1, 4'h5, 4'hA, 20'h12345, 20'h8FFF6, 131,
                                      16'hF0F0, 16'h0F0F, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'hC, 4'h3, 20'h00000, 20'h00000, 137,
                                      16'h1111, 16'h2222, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'hE, 4'hD, 20'hFFFFF, 20'hFFFFF, 138,
                                      16'h3333, 16'h4444, 0, '0));
      directed_rows.push_back(dir_row(1, 0, 4'h9, 4'h6, 20'hAFFF7, 20'h00000, 141,
                                      16'h6666, 16'h7777, 0, '0));
      directed_rows.push_back(dir_row(0, 1, 4'h6, 4'h9, 20'h00000, 20'h4FFF8, 142,
                                      16'h8888, 16'h9999, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'hB, 4'h4, 20'hC0010, 20'hB0010, 145,
                                      16'hBBBB, 16'hCCCC, 0, '0));
      directed_rows.push_back(dir_row(0, 0, 4'h4, 4'hB, 20'h12345, 20'h54321, 146,
                                      16'hDDDD, 16'hEEEE, 0, '0));
      directed_rows.push_back(dir_row(1, 1, 4'hD, 4'h2, 20'h00001, 20'h10000, 148,
                                      16'hFFFE, 16'h7FFF, 0, '0));
      directed_rows.push_back(dir_row(1, 0, 4'h1, 4'hE, 20'h3FFFF, 20'h00000, -1,
                                      16'h7FFF, 16'hFFFE, 0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].req, directed_rows[i].fixed ?
                       directed_rows[i].record : predict_record(directed_rows[i].req));
      end
      wait_for_records();

      for (int phase = 0; phase < 4; phase++) begin
         req_gap_pct = phase_gap_pct[phase];
         rsp_stall_pct = phase_stall_pct[phase];
         repeat (RANDOM_PER_PHASE) begin
            r = random_request();
            offer_request(r, predict_record(r));
         end
         wait_for_records();
         if (phase == 0) begin
            // The response side holds off while requests keep coming, so the pipeline fills.
            hold_off_requests++;
            repeat (BURST_ITEMS) begin
               r = random_request();
               offer_request(r, predict_record(r));
            end
            wait_for_records();
         end
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
